@@ rtl/core/peer_frame_statistics_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// peer frame statistics table assertion macros
// concurrent assertion helpers shared by the table rtl
// ----------------------------------------------------------------------------
`ifndef PEER_FRAME_STATISTICS_TABLE_UNIT_MACROS_SVH
`define PEER_FRAME_STATISTICS_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define PFST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfst assertion failed");

// next-cycle implication
`define PFST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfst assertion failed");

`endif

@@ rtl/core/pfst_pkg.sv @@
// ----------------------------------------------------------------------------
// pfst_pkg
// types and constants of the peer frame statistics table
// ----------------------------------------------------------------------------
package pfst_pkg;

   localparam int MAX_PEERS_DEF = 16;
   localparam int MAC_W         = 48;
   localparam int CNT_W         = 32;

   typedef struct packed {
      logic             req_type;
      logic [MAC_W-1:0] peer_mac;
      logic [CNT_W-1:0] rx_frame_number;
   } pfst_req_beat_type;

   typedef struct packed {
      logic [CNT_W-1:0]        tx_frame_number;
      logic                    peer_was_new;
      logic signed [CNT_W-1:0] error_count;
      logic                    table_full;
   } pfst_rsp_beat_type;

   typedef struct packed {
      logic [MAC_W-1:0] addr;
      logic [CNT_W-1:0] sent;
      logic [CNT_W-1:0] recv;
      logic [CNT_W-1:0] err;
   } pfst_entry_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } pfst_alu_op_type;

   typedef struct packed {
      pfst_alu_op_type  op;
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] b;
   } pfst_alu_req_type;

   localparam logic REQ_TX = 1'b0;
   localparam logic REQ_RX = 1'b1;

endpackage

@@ rtl/core/pfst_store.sv @@
// ----------------------------------------------------------------------------
// pfst_store
// peer entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfst_store #(
   parameter int DEPTH = pfst_pkg::MAX_PEERS_DEF,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  pfst_pkg::pfst_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [IW-1:0]            rd_addr,
   output pfst_pkg::pfst_entry_type rd_data
);

   pfst_pkg::pfst_entry_type mem_ff [DEPTH];
   pfst_pkg::pfst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pfst_alu.sv @@
// ----------------------------------------------------------------------------
// pfst_alu
// shared 32-bit add / subtract unit with registered result
// ----------------------------------------------------------------------------
module pfst_alu (
   input  logic                           clock,
   input  pfst_pkg::pfst_alu_req_type     op_req,
   output logic [pfst_pkg::CNT_W-1:0]     result
);

   logic [pfst_pkg::CNT_W-1:0] result_ff;
   logic [pfst_pkg::CNT_W-1:0] result_in;

   always_comb begin
      unique case (op_req.op)
         pfst_pkg::ALU_ADD: result_in = op_req.a + op_req.b;
         pfst_pkg::ALU_SUB: result_in = op_req.a - op_req.b;
         default:           result_in = op_req.a + op_req.b;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

@@ rtl/core/peer_frame_statistics_table_unit.sv @@
// ----------------------------------------------------------------------------
// peer_frame_statistics_table_unit
// per-peer sent / received / error frame counters with in-order table fill
// ----------------------------------------------------------------------------
// A request names a peer address and a transmit or receive update. The table
// is walked one entry per cycle through the single read port of the entry
// memory, then one shared add/subtract unit does the counter updates in two
// steps and the entry is written back. A request raises rsp_valid as it leaves
// the write state, and req_ready returns on that same cycle, so the next
// request can be accepted while that response is offered; an unknown peer is
// answered only after every filled entry has been compared. req_ready is low
// while a request is in progress; a new request can be taken while the
// previous result still waits on rsp, and its write back then waits until
// that result is taken.
// Entries are not cleared at reset; only entries below the fill count are read.
`include "peer_frame_statistics_table_unit_macros.svh"

module peer_frame_statistics_table_unit #(
   parameter int MAX_PEERS = pfst_pkg::MAX_PEERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pfst_pkg::pfst_req_beat_type req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pfst_pkg::pfst_rsp_beat_type rsp_data
);

   localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW = $clog2(MAX_PEERS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PEERS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_CALC_A = 6'b000100,
      ST_CALC_B = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_SPARE  = 6'b100000
   } pfst_state_type;

   pfst_state_type              state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [IW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic                        hit_ff, hit_in;
   logic [IW-1:0]               pos_ff, pos_in;
   logic [pfst_pkg::CNT_W-1:0]  tx_num_ff, tx_num_in;
   pfst_pkg::pfst_req_beat_type req_ff, req_in;
   pfst_pkg::pfst_entry_type    row_ff, row_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pfst_pkg::pfst_rsp_beat_type rsp_ff, rsp_in;

   pfst_pkg::pfst_entry_type    rd_data;
   pfst_pkg::pfst_entry_type    wr_data;
   logic                        rd_en;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   pfst_pkg::pfst_alu_req_type  alu_req;
   logic [pfst_pkg::CNT_W-1:0]  alu_y;

   logic match;
   logic last_cmp;
   logic is_full;
   logic is_rx;
   logic rsp_free;

   assign is_rx    = (req_ff.req_type == pfst_pkg::REQ_RX);
   assign is_full  = (count_ff == FULL_COUNT);
   assign match    = cmp_vld_ff && (rd_data.addr == req_ff.peer_mac);
   assign last_cmp = (CW'(cmp_idx_ff) + CW'(1)) == count_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // memory read during the walk
   assign rd_en = (state_ff == ST_SEARCH) && (idx_ff < count_ff) && !match;

   // write back at the end
   assign wr_en   = (state_ff == ST_WRITE) && rsp_free && (hit_ff || !is_full);
   assign wr_addr = hit_ff ? pos_ff : count_ff[IW-1:0];
   always_comb begin
      wr_data = row_ff;
      if (hit_ff && is_rx) begin
         wr_data.recv = alu_y;
      end
   end

   // shared unit operand selection
   always_comb begin
      alu_req.op = pfst_pkg::ALU_ADD;
      alu_req.a  = row_ff.recv;
      alu_req.b  = pfst_pkg::CNT_W'(1);
      if (state_ff == ST_CALC_A) begin
         priority if (!hit_ff) begin
            alu_req.a = req_ff.rx_frame_number;
         end else if (is_rx) begin
            alu_req.op = pfst_pkg::ALU_SUB;
            alu_req.a  = req_ff.rx_frame_number;
            alu_req.b  = row_ff.recv;
         end else begin
            alu_req.a = row_ff.sent;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      tx_num_in    = tx_num_ff;
      req_in       = req_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (rd_en) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[IW-1:0];
               idx_in     = idx_ff + CW'(1);
            end
            priority if (match) begin
               hit_in    = 1'b1;
               pos_in    = cmp_idx_ff;
               row_in    = rd_data;
               tx_num_in = is_rx ? '0 : rd_data.sent;
               state_in  = ST_CALC_A;
            end else if ((cmp_vld_ff && last_cmp) || (count_ff == '0)) begin
               hit_in    = 1'b0;
               tx_num_in = is_rx ? '0 : pfst_pkg::CNT_W'(1);
               state_in  = ST_CALC_A;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_CALC_A: begin
            state_in = ST_CALC_B;
         end
         ST_CALC_B: begin
            priority if (!hit_ff) begin
               row_in.addr = req_ff.peer_mac;
               row_in.sent = is_rx ? '0 : pfst_pkg::CNT_W'(1);
               row_in.recv = is_rx ? alu_y : '0;
               row_in.err  = '0;
            end else if (is_rx) begin
               row_in.err = alu_y;
            end else begin
               row_in.sent = alu_y;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.tx_frame_number = tx_num_ff;
               rsp_in.peer_was_new    = !hit_ff;
               rsp_in.error_count     = hit_ff ? $signed(row_ff.err) : '0;
               rsp_in.table_full      = !hit_ff && is_full;
               if (!hit_ff && !is_full) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      tx_num_ff  <= tx_num_in;
      req_ff     <= req_in;
      row_ff     <= row_in;
      rsp_ff     <= rsp_in;
   end

   pfst_store #(
      .DEPTH (MAX_PEERS),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   pfst_alu u_alu (
      .clock  (clock),
      .op_req (alu_req),
      .result (alu_y)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PFST_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `PFST_ASSERT_NEXT(a_count_only_on_write, clock, reset, state_ff != ST_WRITE,
                     $stable(count_ff))
   `PFST_ASSERT_IMPL(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff) == ST_WRITE)
   `PFST_ASSERT_IMPL(a_cmp_in_range, clock, reset, cmp_vld_ff,
                     CW'(cmp_idx_ff) < count_ff)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the peer frame statistics table unit
// ----------------------------------------------------------------------------
// A directed table covers the first peers, the counter extremes and the full
// table, followed by random updates aimed mostly at known peers. Every request
// beat accepted is run through a local model of the peer table, and each
// response beat is checked field by field against the oldest prediction.
// Both channels idle and stall at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int PEER_SLOTS     = pfst_pkg::MAX_PEERS_DEF;
   localparam int DIRECTED_ROWS  = 28;
   localparam int RANDOM_BEATS   = 822;
   localparam int TOTAL_BEATS    = DIRECTED_ROWS + RANDOM_BEATS;
   localparam int IDLE_PERCENT   = 29;
   localparam int QUIET_FIRST    = 400;
   localparam int QUIET_LAST     = 560;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic                        typed;
      pfst_pkg::pfst_req_beat_type beat;
      pfst_pkg::pfst_rsp_beat_type want;
   } probe_row_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   pfst_pkg::pfst_req_beat_type req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   pfst_pkg::pfst_rsp_beat_type rsp_data;

   logic [pfst_pkg::MAC_W-1:0] peer_addr [PEER_SLOTS];
   logic [pfst_pkg::CNT_W-1:0] peer_sent [PEER_SLOTS];
   logic [pfst_pkg::CNT_W-1:0] peer_recv [PEER_SLOTS];
   logic [pfst_pkg::CNT_W-1:0] peer_err  [PEER_SLOTS];
   int                         peer_fill = 0;

   pfst_pkg::pfst_rsp_beat_type rsp_expect_q [$];
   int                          beats_offered = 0;
   int                          beats_taken   = 0;
   int                          failures      = 0;
   int                          stall_cycles  = 0;
   logic                        drained       = 1'b0;

   // directed beats; untyped rows rely on the table model
   probe_row_type probe_rows [DIRECTED_ROWS] = '{
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_0000_0000, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_0000_0000, 32'hFFFF_FFFF},
            '{32'd1, 1'b0, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_0000_0000, 32'h0000_0000},
            '{32'd2, 1'b0, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFF, 32'h0000_0000},
            '{32'd0, 1'b0, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFF, 32'h0000_0000},
            '{32'd0, 1'b0, -32'sd1, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFF, 32'h8000_0001},
            '{32'd0, 1'b0, 32'sh7FFF_FFFF, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFF, 32'h8000_0003},
            '{32'd0, 1'b0, 32'sh8000_0000, 1'b0}},
      '{1'b0, '{pfst_pkg::REQ_TX, 48'hFFFF_FFFF_FFFF, 32'h1234_5678}, '0},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'h0000_0000_0000, 32'h0000_0005},
            '{32'd0, 1'b0, 32'sd5, 1'b0}},
      '{1'b0, '{pfst_pkg::REQ_TX, 48'h0000_0000_0000, 32'h0000_0000}, '0},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_0000_0001, 32'hFFFF_FFFF},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'h8000_0000_0000, 32'h0000_0000},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h5555_5555_5555, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hAAAA_AAAA_AAAA, 32'h7FFF_FFFF},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0123_4567_89AB, 32'h5555_5555},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFEDC_BA98_7654, 32'h8000_0000},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_FFFF_0000, 32'hAAAA_AAAA},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_0000_FFFF, 32'hFFFF_FFFE},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0F0F_0F0F_0F0F, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hF0F0_F0F0_F0F0, 32'h1234_5678},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h7FFF_FFFF_FFFF, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'hFFFF_FFFF_FFFE, 32'hDEAD_BEEF},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h1000_0000_0001, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'h00C0_FFEE_0001, 32'h0000_0001},
            '{32'd0, 1'b1, 32'sd0, 1'b0}},
      '{1'b1, '{pfst_pkg::REQ_TX, 48'h0000_0000_0002, 32'h0000_0000},
            '{32'd1, 1'b1, 32'sd0, 1'b1}},
      '{1'b1, '{pfst_pkg::REQ_RX, 48'h0000_0000_0003, 32'hFFFF_FFFF},
            '{32'd0, 1'b1, 32'sd0, 1'b1}},
      '{1'b0, '{pfst_pkg::REQ_RX, 48'h00C0_FFEE_0001, 32'h0000_0000}, '0}
   };

   peer_frame_statistics_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // peer table model: look up, update counters, fill in order of first use
   function automatic pfst_pkg::pfst_rsp_beat_type apply_peer_update(
         pfst_pkg::pfst_req_beat_type beat);
      pfst_pkg::pfst_rsp_beat_type res;
      int                          hit;
      res = '0;
      hit = -1;
      for (int i = 0; i < peer_fill; i++) begin
         if (hit < 0 && peer_addr[i] == beat.peer_mac) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         if (beat.req_type == pfst_pkg::REQ_RX) begin
            peer_err[hit]  = beat.rx_frame_number - peer_recv[hit];
            peer_recv[hit] = peer_recv[hit] + 32'd1;
         end else begin
            res.tx_frame_number = peer_sent[hit];
            peer_sent[hit]      = peer_sent[hit] + 32'd1;
         end
         res.error_count = peer_err[hit];
      end else begin
         res.peer_was_new = 1'b1;
         if (beat.req_type == pfst_pkg::REQ_TX) begin
            res.tx_frame_number = 32'd1;
         end
         if (peer_fill < PEER_SLOTS) begin
            peer_addr[peer_fill] = beat.peer_mac;
            peer_sent[peer_fill] = (beat.req_type == pfst_pkg::REQ_RX) ? 32'd0 : 32'd1;
            peer_recv[peer_fill] = (beat.req_type == pfst_pkg::REQ_RX) ?
                                   beat.rx_frame_number + 32'd1 : 32'd0;
            peer_err[peer_fill]  = '0;
            peer_fill++;
         end else begin
            res.table_full = 1'b1;
         end
      end
      return res;
   endfunction

   // random beats mostly hit known peers, half of those with frame numbers near the expected one
   function automatic pfst_pkg::pfst_req_beat_type pick_request(int n);
      pfst_pkg::pfst_req_beat_type beat;
      int                          slot;
      if (n < DIRECTED_ROWS) begin
         return probe_rows[n].beat;
      end
      beat.req_type        = $urandom_range(0, 1) ? pfst_pkg::REQ_RX : pfst_pkg::REQ_TX;
      beat.rx_frame_number = $urandom;
      if (peer_fill > 0 && $urandom_range(0, 99) < 80) begin
         slot          = $urandom_range(0, peer_fill - 1);
         beat.peer_mac = peer_addr[slot];
         if ($urandom_range(0, 1)) begin
            beat.rx_frame_number = peer_recv[slot]
                                   + pfst_pkg::CNT_W'($urandom_range(0, 8)) - 32'd4;
         end
      end else begin
         beat.peer_mac = {16'($urandom), 32'($urandom)};
      end
      return beat;
   endfunction

   task automatic report_field(string name, logic [pfst_pkg::CNT_W-1:0] want,
                               logic [pfst_pkg::CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      pfst_pkg::pfst_rsp_beat_type want;
      logic                        progress;
      logic                        quiet;
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = apply_peer_update(req_data);
            if (beats_taken < DIRECTED_ROWS && probe_rows[beats_taken].typed) begin
               want = probe_rows[beats_taken].want;
            end
            rsp_expect_q = {rsp_expect_q, want};
            beats_taken++;
            progress = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: unexpected response beat %0h", $time, rsp_data);
               failures++;
            end else begin
               want = rsp_expect_q.pop_front();
               report_field("tx_frame_number", want.tx_frame_number,
                            rsp_data.tx_frame_number);
               report_field("peer_was_new", 32'(want.peer_was_new),
                            32'(rsp_data.peer_was_new));
               report_field("error_count", want.error_count, rsp_data.error_count);
               report_field("table_full", 32'(want.table_full), 32'(rsp_data.table_full));
            end
         end
         quiet = beats_offered >= QUIET_FIRST && beats_offered < QUIET_LAST;
         if (!(req_valid && !req_ready)) begin
            if (beats_offered < TOTAL_BEATS &&
                (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_data  <= pick_request(beats_offered);
               req_valid <= 1'b1;
               beats_offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready    <= quiet || $urandom_range(0, 99) >= IDLE_PERCENT;
         stall_cycles <= progress ? 0 : stall_cycles + 1;
         drained      <= beats_taken == TOTAL_BEATS && rsp_expect_q.size() == 0;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!drained && stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      if (stall_cycles < WATCHDOG_LIMIT) begin
         repeat (TAIL_CYCLES) @(posedge clock);
      end else begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time,
                  rsp_expect_q.size());
      end
      @(negedge clock);
      if (failures == 0 && stall_cycles < WATCHDOG_LIMIT) begin
         $display("peer_frame_statistics_table_unit verification clean");
      end else begin
         $display("peer_frame_statistics_table_unit verification failed");
      end
      $finish;
   end

endmodule
